// File: rtl/bit_matrix_transitive_closure_unit_macros.svh
// Assertion macros used by the closure unit checker.
`ifndef BIT_MATRIX_TRANSITIVE_CLOSURE_UNIT_MACROS_SVH
`define BIT_MATRIX_TRANSITIVE_CLOSURE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BMTC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define BMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bmtc_pkg.sv
// Shared widths, defaults and the column mask helper for the closure unit.
`default_nettype none

package bmtc_pkg;

   localparam int ROW_W         = 64;
   localparam int IDX_W         = 6;
   localparam int CNT_W         = 7;
   localparam int NODES_DEFAULT = 64;

   localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   // Bit j set for every column j below n.
   function automatic logic [ROW_W-1:0] column_mask(input logic [CNT_W-1:0] n);
      logic [ROW_W-1:0] m;
      for (int j = 0; j < ROW_W; j++) begin
         m[j] = (CNT_W'(j) < n);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bit_matrix_transitive_closure_unit.sv
// Load rows are taken only while idle; req_stall is high otherwise. The last row starts
// the closure: one pivot pass per node in use, each reading every row from the single
// matrix memory and writing back the rows that hold the pivot column. Results: each row
// is read, then emitted once the output is free. No new item is taken from the last row
// until all are emitted. Reset (synchronous, active high) clears the row valid bits, the
// cycle flag, the sequencer and the output; node_count returns to 64.
`default_nettype none

module bit_matrix_transitive_closure_unit
   import bmtc_pkg::*;
#(
   parameter int MAX_NODES = NODES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data,

   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [IDX_W-1:0] req_row_index,
   input  wire logic [ROW_W-1:0] req_row_bits,
   input  wire logic             req_last_row,

   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [IDX_W-1:0]      rsp_out_node,
   output logic [ROW_W-1:0]      rsp_reach_bits,
   output logic                  rsp_cyclic,
   output logic                  rsp_last_out
);

   localparam int AW = $clog2(MAX_NODES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PIV   = 3'd1;
   localparam logic [2:0] S_PWAIT = 3'd2;
   localparam logic [2:0] S_ROW   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_ERD   = 3'd5;
   localparam logic [2:0] S_EWR   = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        k_ff, k_in;
   logic [AW-1:0]        x_ff, x_in;
   logic [AW-1:0]        xd_ff, xd_in;
   logic [AW-1:0]        nm1_ff, nm1_in;
   logic                 dv_ff, dv_in;
   logic                 cyc_ff, cyc_in;
   logic [CNT_W-1:0]     node_count_ff, node_count_in;
   logic [ROW_W-1:0]     mask_ff, mask_in;
   logic [ROW_W-1:0]     piv_ff, piv_in;
   logic [MAX_NODES-1:0] vld_ff, vld_in;
   logic [ROW_W-1:0]     rd_data_ff;
   logic                 rd_vld_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_node_ff, rsp_node_in;
   logic [ROW_W-1:0]     rsp_bits_ff, rsp_bits_in;
   logic                 rsp_cyc_ff, rsp_cyc_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [ROW_W-1:0]     wr_data;

   logic [ROW_W-1:0]     row_eff;
   logic                 pivot_hit;
   logic [ROW_W-1:0]     new_row;
   logic [CNT_W-1:0]     n_use;
   logic                 out_free;

   logic [ROW_W-1:0]     mem [MAX_NODES];

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_node   = rsp_node_ff;
   assign rsp_reach_bits = rsp_bits_ff;
   assign rsp_cyclic     = rsp_cyc_ff;
   assign rsp_last_out   = rsp_last_ff;

   // never-written rows read as zero; columns past the node count are dropped on read
   assign row_eff   = rd_vld_ff ? (rd_data_ff & mask_ff) : '0;
   assign pivot_hit = row_eff[IDX_W'(k_ff)];
   assign new_row   = pivot_hit ? (row_eff | piv_ff) : row_eff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      priority if (node_count_ff == '0) begin
         n_use = CNT_W'(1);
      end else if (node_count_ff > CNT_W'(MAX_NODES)) begin
         n_use = CNT_W'(MAX_NODES);
      end else begin
         n_use = node_count_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      x_in          = x_ff;
      xd_in         = xd_ff;
      nm1_in        = nm1_ff;
      dv_in         = 1'b0;
      cyc_in        = cyc_ff;
      mask_in       = mask_ff;
      piv_in        = piv_ff;
      vld_in        = vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_cyc_in    = rsp_cyc_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = x_ff;
      wr_en         = 1'b0;
      wr_addr       = xd_ff;
      wr_data       = new_row;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // write-back stage of a row pass
      if (dv_ff) begin
         if (pivot_hit) begin
            wr_en         = 1'b1;
            vld_in[xd_ff] = 1'b1;
         end
         if (k_ff == nm1_ff && new_row[IDX_W'(xd_ff)]) begin
            cyc_in = 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if ({1'b0, req_row_index} < CNT_W'(MAX_NODES)) begin
                  wr_en                      = 1'b1;
                  wr_addr                    = req_row_index[AW-1:0];
                  wr_data                    = req_row_bits;
                  vld_in[req_row_index[AW-1:0]] = 1'b1;
               end
               if (req_last_row) begin
                  nm1_in   = AW'(n_use - CNT_W'(1));
                  mask_in  = column_mask(n_use);
                  k_in     = '0;
                  state_in = S_PIV;
               end
            end
         end
         S_PIV: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            piv_in   = row_eff;
            x_in     = '0;
            state_in = S_ROW;
         end
         S_ROW: begin
            rd_en   = 1'b1;
            rd_addr = x_ff;
            dv_in   = 1'b1;
            xd_in   = x_ff;
            if (x_ff == nm1_ff) begin
               state_in = S_DRAIN;
            end else begin
               x_in = x_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            if (k_ff == nm1_ff) begin
               x_in     = '0;
               state_in = S_ERD;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = S_PIV;
            end
         end
         S_ERD: begin
            rd_en    = 1'b1;
            rd_addr  = x_ff;
            state_in = S_EWR;
         end
         S_EWR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = IDX_W'(x_ff);
               rsp_bits_in  = row_eff;
               rsp_cyc_in   = cyc_ff;
               rsp_last_in  = (x_ff == nm1_ff);
               if (x_ff == nm1_ff) begin
                  vld_in   = '0;
                  cyc_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  x_in     = x_ff + AW'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         dv_ff         <= 1'b0;
         cyc_ff        <= 1'b0;
         vld_ff        <= '0;
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dv_ff         <= dv_in;
         cyc_ff        <= cyc_in;
         vld_ff        <= vld_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      x_ff        <= x_in;
      xd_ff       <= xd_in;
      nm1_ff      <= nm1_in;
      mask_ff     <= mask_in;
      piv_ff      <= piv_in;
      rsp_node_ff <= rsp_node_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_cyc_ff  <= rsp_cyc_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// File: rtl/bmtc_checker.sv
// Port-level checks for the closure unit, bound to the top level.
`default_nettype none

`include "bit_matrix_transitive_closure_unit_macros.svh"

module bmtc_checker
   import bmtc_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             req_last_row,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [IDX_W-1:0] rsp_out_node,
   input wire logic [ROW_W-1:0] rsp_reach_bits,
   input wire logic             rsp_cyclic,
   input wire logic             rsp_last_out
);

   `BMTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_node) && $stable(rsp_reach_bits) && $stable(rsp_cyclic) && $stable(rsp_last_out), "stalled item changed")
   `BMTC_ASSERT_NOW(a_burst_busy, rsp_valid && !rsp_last_out, req_stall, "input taken mid burst")
   `BMTC_ASSERT_NEXT(a_last_busy, req_valid && !req_stall && req_last_row, req_stall, "closure did not start")

endmodule

bind bit_matrix_transitive_closure_unit bmtc_checker u_bmtc_checker (.*);

`default_nettype wire
